// ----- rtl/core/dmtt_pkg.sv -----
`default_nettype none
package dmtt_pkg;

  // table geometry, slot index is the low key bits (power-of-two entry count)
  localparam int TABLE_ENTRIES = 65536;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // field widths
  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 7;
  localparam int SCORE_W = 16;
  localparam int FLAG_W  = 2;
  localparam int MOVE_W  = 16;
  localparam int AGE_W   = 8;
  localparam int CNT_W   = 32;
  localparam int CMD_W   = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_STORE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PROBE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // one table slot as held in memory
  typedef struct packed {
    logic                      valid;
    logic [AGE_W-1:0]          age;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [FLAG_W-1:0]         flag;
    logic [MOVE_W-1:0]         move;
    logic [KEY_W-1:0]          key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // finished item handed to the response stage
  typedef struct packed {
    logic                      load;
    logic                      probe;
    logic                      hit;
    logic                      wipe;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [FLAG_W-1:0]         flag;
    logic [MOVE_W-1:0]         move;
  } ev_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_WIPE = 3'b100
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/dmtt_ram.sv -----
`default_nettype none
module dmtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/dmtt_resp.sv -----
`default_nettype none
module dmtt_resp (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire dmtt_pkg::ev_t                              ev,
  input  wire logic                                       out_ready,
  output      logic                                       out_valid,
  output      logic                                       hit,
  output      logic [dmtt_pkg::DEPTH_W-1:0]               entry_depth,
  output      logic signed [dmtt_pkg::SCORE_W-1:0]        entry_score,
  output      logic [dmtt_pkg::FLAG_W-1:0]                entry_flag,
  output      logic [dmtt_pkg::MOVE_W-1:0]                entry_move,
  output      logic [dmtt_pkg::CNT_W-1:0]                 hit_total,
  output      logic [dmtt_pkg::CNT_W-1:0]                 miss_total
);

  logic hit_out;

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ev.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // entry fields, zero unless the probe hit
  assign hit_out = ev.probe & ev.hit;

  always_ff @(posedge clk) begin
    if (ev.load) begin
      hit         <= hit_out;
      entry_depth <= hit_out ? ev.depth : '0;
      entry_score <= hit_out ? ev.score : '0;
      entry_flag  <= hit_out ? ev.flag  : '0;
      entry_move  <= hit_out ? ev.move  : '0;
    end
  end

  // saturating hit and miss counters, they only move when a beat is loaded; a clear zeroes them
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total  <= '0;
      miss_total <= '0;
    end else if (ev.load) begin
      if (ev.wipe) begin
        hit_total  <= '0;
        miss_total <= '0;
      end else if (ev.probe && ev.hit) begin
        if (hit_total != '1) begin
          hit_total <= hit_total + 1'b1;
        end
      end else if (ev.probe) begin
        if (miss_total != '1) begin
          miss_total <= miss_total + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/direct_mapped_transposition_table_top.sv -----
// path: a store or probe beat reads its slot, then in ST_READ loads the output once it is free
// no overlap: a new store or probe is taken only back in ST_IDLE (slot read, then write-back)
// clear: sweeps every slot, one per cycle, then reports on the output once it is free
// reset: counters and age go to zero, then a sweep invalidates all slots;
// in_ready stays low during the sweep, configuration writes are taken throughout
`default_nettype none
module direct_mapped_transposition_table_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [dmtt_pkg::AGE_W-1:0]          cfg_data,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic [dmtt_pkg::CMD_W-1:0]          cmd,
  input  wire logic [dmtt_pkg::KEY_W-1:0]          key,
  input  wire logic [dmtt_pkg::DEPTH_W-1:0]        depth,
  input  wire logic signed [dmtt_pkg::SCORE_W-1:0] score,
  input  wire logic [dmtt_pkg::FLAG_W-1:0]         bound_flag,
  input  wire logic [dmtt_pkg::MOVE_W-1:0]         best_move,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic                                hit,
  output      logic [dmtt_pkg::DEPTH_W-1:0]        entry_depth,
  output      logic signed [dmtt_pkg::SCORE_W-1:0] entry_score,
  output      logic [dmtt_pkg::FLAG_W-1:0]         entry_flag,
  output      logic [dmtt_pkg::MOVE_W-1:0]         entry_move,
  output      logic [dmtt_pkg::CNT_W-1:0]          hit_total,
  output      logic [dmtt_pkg::CNT_W-1:0]          miss_total
);

  dmtt_pkg::state_t                    state;
  dmtt_pkg::state_t                    state_next;
  logic [dmtt_pkg::AGE_W-1:0]          current_age;
  logic [dmtt_pkg::CMD_W-1:0]          cmd_q;
  logic [dmtt_pkg::KEY_W-1:0]          key_q;
  logic [dmtt_pkg::DEPTH_W-1:0]        depth_q;
  logic signed [dmtt_pkg::SCORE_W-1:0] score_q;
  logic [dmtt_pkg::FLAG_W-1:0]         flag_q;
  logic [dmtt_pkg::MOVE_W-1:0]         move_q;
  logic [dmtt_pkg::IDX_W-1:0]          wipe_idx;
  logic                                wipe_report;
  logic                                in_beat;
  logic                                resp_busy;
  logic                                go;
  logic                                take;
  logic                                match;
  logic                                wipe_last;
  logic                                ram_we;
  logic [dmtt_pkg::IDX_W-1:0]          ram_waddr;
  logic [dmtt_pkg::ENTRY_W-1:0]        ram_wdata;
  logic [dmtt_pkg::ENTRY_W-1:0]        ram_rdata;
  dmtt_pkg::entry_t                    old;
  dmtt_pkg::entry_t                    fresh;
  dmtt_pkg::ev_t                       ev;

  assign in_ready  = (state == dmtt_pkg::ST_IDLE);
  assign in_beat   = in_valid & in_ready;
  assign resp_busy = out_valid & ~out_ready;
  assign go        = (state == dmtt_pkg::ST_READ) & ~resp_busy;
  assign wipe_last = (wipe_idx == dmtt_pkg::LAST_IDX);

  // age register
  always_ff @(posedge clk) begin
    if (rst) begin
      current_age <= '0;
    end else if (cfg_we) begin
      current_age <= cfg_data;
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_q   <= cmd;
      key_q   <= key;
      depth_q <= depth;
      score_q <= score;
      flag_q  <= bound_flag;
      move_q  <= best_move;
    end
  end

  // slot compare and replacement decision on the registered read data
  assign old   = dmtt_pkg::entry_t'(ram_rdata);
  assign match = old.valid & (old.key == key_q);
  assign take  = ~old.valid | (old.depth <= depth_q) | (old.age < current_age);

  always_comb begin
    fresh.valid = 1'b1;
    fresh.age   = current_age;
    fresh.depth = depth_q;
    fresh.score = score_q;
    fresh.flag  = flag_q;
    fresh.move  = move_q;
    fresh.key   = key_q;
  end

  // write port: the invalidate sweep or a store write-back
  always_comb begin
    if (state == dmtt_pkg::ST_WIPE) begin
      ram_we    = 1'b1;
      ram_waddr = wipe_idx;
      ram_wdata = '0;
    end else begin
      ram_we    = go & (cmd_q == dmtt_pkg::CMD_STORE) & take;
      ram_waddr = key_q[dmtt_pkg::IDX_W-1:0];
      ram_wdata = fresh;
    end
  end

  dmtt_ram #(
    .WIDTH (dmtt_pkg::ENTRY_W),
    .DEPTH (dmtt_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_beat),
    .raddr (key[dmtt_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // controller
  always_comb begin
    state_next = state;
    case (state)
      dmtt_pkg::ST_IDLE: begin
        if (in_beat) begin
          state_next = (cmd == dmtt_pkg::CMD_CLEAR) ? dmtt_pkg::ST_WIPE : dmtt_pkg::ST_READ;
        end
      end
      dmtt_pkg::ST_READ: begin
        if (go) begin
          state_next = dmtt_pkg::ST_IDLE;
        end
      end
      dmtt_pkg::ST_WIPE: begin
        if (wipe_last && (!wipe_report || !resp_busy)) begin
          state_next = dmtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dmtt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmtt_pkg::ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  // sweep index, held on the last slot while the clear beat waits
  always_ff @(posedge clk) begin
    if (rst) begin
      wipe_idx    <= '0;
      wipe_report <= 1'b0;
    end else if (in_beat && cmd == dmtt_pkg::CMD_CLEAR) begin
      wipe_idx    <= '0;
      wipe_report <= 1'b1;
    end else if (state == dmtt_pkg::ST_WIPE && !wipe_last) begin
      wipe_idx <= wipe_idx + 1'b1;
    end
  end

  // hand the finished item to the response stage
  always_comb begin
    ev.load  = go | ((state == dmtt_pkg::ST_WIPE) & wipe_last & wipe_report & ~resp_busy);
    ev.probe = (state == dmtt_pkg::ST_READ) & (cmd_q == dmtt_pkg::CMD_PROBE);
    ev.hit   = match;
    ev.wipe  = (state == dmtt_pkg::ST_WIPE);
    ev.depth = old.depth;
    ev.score = old.score;
    ev.flag  = old.flag;
    ev.move  = old.move;
  end

  dmtt_resp u_resp (
    .clk         (clk),
    .rst         (rst),
    .ev          (ev),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .hit         (hit),
    .entry_depth (entry_depth),
    .entry_score (entry_score),
    .entry_flag  (entry_flag),
    .entry_move  (entry_move),
    .hit_total   (hit_total),
    .miss_total  (miss_total)
  );

  // no memory write while waiting for a beat
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == dmtt_pkg::ST_IDLE) |-> !ram_we)
    else $error("memory written while idle");

  // an accepted beat always moves on to a read or a sweep
  a_beat_moves: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == dmtt_pkg::ST_READ || state == dmtt_pkg::ST_WIPE))
    else $error("accepted beat left the controller idle");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ev.load |-> !resp_busy)
    else $error("result loaded over a stalled output beat");

  // the sweep advances one slot per cycle until the last one
  a_sweep_step: assert property (@(posedge clk) disable iff (rst)
    (state == dmtt_pkg::ST_WIPE && !wipe_last) |=> (wipe_idx == $past(wipe_idx) + 1'b1))
    else $error("sweep index skipped or stalled");

endmodule
`default_nettype wire
